### hw/rtl/assert_macros.svh
// assertion macros used by bitmap_slot_allocator
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is asserted
`define BSA_ASSERT_CLK(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// clocked assertion on clk and rst_n of the enclosing module
`define BSA_ASSERT(name, prop, msg) \
    `BSA_ASSERT_CLK(name, clk, rst_n, prop, msg)

`endif

### hw/rtl/bsa_pkg.sv
// bitmap slot allocator package: field widths, codes and sequencer states
// no dependencies
package bsa_pkg;

    localparam int HANDLE_W  = 11;
    localparam int EBYTES_W  = 13;
    localparam int OFFSET_W  = 23;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 40;
    localparam int M_PAD_W   = M_TDATA_W - HANDLE_W - OFFSET_W;

    localparam logic [EBYTES_W-1:0] EBYTES_RESET = 13'd16;

    localparam logic OP_FREE = 1'b1;

    localparam logic ST_DONE    = 1'b0;
    localparam logic ST_NOSPACE = 1'b1;

    typedef enum logic [7:0] {
        S_CLR  = 8'b0000_0001,
        S_IDLE = 8'b0000_0010,
        S_READ = 8'b0000_0100,
        S_EVAL = 8'b0000_1000,
        S_FCL  = 8'b0001_0000,
        S_FWD  = 8'b0010_0000,
        S_FCLR = 8'b0100_0000,
        S_MUL  = 8'b1000_0000
    } bsa_state_t;

endpackage

### hw/rtl/bsa_word_scan.sv
// lowest free slot search over one bitmap word
// standalone, used by bitmap_slot_allocator
module bsa_word_scan #(
    parameter int WORD_BITS = 64,
    localparam int BIT_W = $clog2(WORD_BITS)
) (
    input  logic [WORD_BITS-1:0] word,
    input  logic [BIT_W-1:0]     fill_bits,
    input  logic                 full,
    output logic                 found,
    output logic [WORD_BITS-1:0] onehot,
    output logic [BIT_W-1:0]     index
);

    logic [WORD_BITS-1:0] vmask;
    logic [WORD_BITS-1:0] avail;

    assign vmask  = full ? {WORD_BITS{1'b1}}
                         : ((WORD_BITS'(1) << fill_bits) - WORD_BITS'(1));
    assign avail  = ~word & vmask;
    assign onehot = avail & (~avail + WORD_BITS'(1));
    assign found  = |avail;

    // one-hot to binary
    always_comb
    begin
        index = '0;
        for (int b = 0; b < WORD_BITS; b++)
        begin
            index = index | (onehot[b] ? BIT_W'(b) : '0);
        end
    end

endmodule

### hw/rtl/bitmap_slot_allocator.sv
// first-fit slot allocator over per-cluster bitmap words, top level
// depends on bsa_pkg, bsa_word_scan and assert_macros.svh
// allocate: reads bitmap words in turn from the hint cluster onward, per beat
// free: skips whole clusters, then words, to reach the slot, then clears its bit, per beat
// result is registered once ready returns and valid in the cycle after; a stalled result holds the sequencer
// after reset a clearing pass writes zero to every bitmap word in turn
`include "assert_macros.svh"

module bitmap_slot_allocator #(
    parameter int NUM_CLUSTERS      = 8,
    parameter int SLOTS_PER_CLUSTER = 256,
    parameter int WORD_BITS         = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [bsa_pkg::EBYTES_W-1:0]  cfg_wdata,   // element_bytes
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [bsa_pkg::S_TDATA_W-1:0] s_tdata,     // slot_handle
    input  logic [0:0]                    s_tuser,     // op
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [bsa_pkg::M_TDATA_W-1:0] m_tdata,     // granted_handle, byte_offset
    output logic [0:0]                    m_tuser      // status
);

    localparam int WPC         = (SLOTS_PER_CLUSTER + WORD_BITS - 1) / WORD_BITS;
    localparam int TOTAL_WORDS = NUM_CLUSTERS * WPC;
    localparam int ADDR_W      = (TOTAL_WORDS > 1) ? $clog2(TOTAL_WORDS) : 1;
    localparam int CL_W        = (NUM_CLUSTERS > 1) ? $clog2(NUM_CLUSTERS) : 1;
    localparam int TOTAL_SLOTS = NUM_CLUSTERS * SLOTS_PER_CLUSTER;
    localparam int POS_W       = $clog2(TOTAL_SLOTS + 1);
    localparam int CMP_W       = ((POS_W > bsa_pkg::HANDLE_W) ? POS_W : bsa_pkg::HANDLE_W) + 1;
    localparam int REM_W       = $clog2(SLOTS_PER_CLUSTER + 1);
    localparam int BIT_W       = $clog2(WORD_BITS);
    localparam int PROD_W      = bsa_pkg::HANDLE_W + bsa_pkg::EBYTES_W;

    bsa_pkg::bsa_state_t state_reg, state_next;

    logic [ADDR_W-1:0]             addr_reg, addr_next;
    logic [CL_W-1:0]               cl_reg, cl_next;
    logic [POS_W-1:0]              pos_reg, pos_next;
    logic [REM_W-1:0]              wrem_reg, wrem_next;
    logic [POS_W-1:0]              cbase_reg, cbase_next;
    logic [ADDR_W-1:0]             cbase_addr_reg, cbase_addr_next;
    logic [CL_W-1:0]               hint_reg, hint_next;
    logic [ADDR_W-1:0]             hint_addr_reg, hint_addr_next;
    logic [POS_W-1:0]              hint_base_reg, hint_base_next;
    logic [bsa_pkg::EBYTES_W-1:0]  eb_reg, eb_next;
    logic                          ovalid_reg, ovalid_next;

    logic [bsa_pkg::HANDLE_W-1:0]  handle_reg, handle_next;
    logic [BIT_W-1:0]              bit_reg, bit_next;
    logic [bsa_pkg::HANDLE_W-1:0]  gh_reg, gh_next;
    logic                          status_reg, status_next;
    logic [bsa_pkg::HANDLE_W-1:0]  out_handle_reg, out_handle_next;
    logic [bsa_pkg::OFFSET_W-1:0]  out_offset_reg, out_offset_next;
    logic                          out_status_reg, out_status_next;

    logic [WORD_BITS-1:0]          mem [TOTAL_WORDS];
    logic [WORD_BITS-1:0]          rdata_reg;
    logic                          mem_we;
    logic [WORD_BITS-1:0]          mem_wdata;

    logic                          scan_found;
    logic [WORD_BITS-1:0]          scan_onehot;
    logic [BIT_W-1:0]              scan_index;

    logic [CMP_W-1:0]              pos_ext;
    logic [CMP_W-1:0]              handle_ext;
    logic [CMP_W-1:0]              pos_p_spc;
    logic [CMP_W-1:0]              pos_p_wb;
    logic [CMP_W-1:0]              pos_p_rem;
    logic                          wrem_full;
    logic                          last_cluster;
    logic                          out_free;
    logic [PROD_W-1:0]             prod;

    assign pos_ext      = CMP_W'(pos_reg);
    assign handle_ext   = CMP_W'(handle_reg);
    assign pos_p_spc    = pos_ext + CMP_W'(SLOTS_PER_CLUSTER);
    assign pos_p_wb     = pos_ext + CMP_W'(WORD_BITS);
    assign pos_p_rem    = pos_ext + CMP_W'(wrem_reg);
    assign wrem_full    = (wrem_reg >= REM_W'(WORD_BITS));
    assign last_cluster = (cl_reg == CL_W'(NUM_CLUSTERS - 1));
    assign out_free     = !ovalid_reg || m_tready;
    assign prod         = gh_reg * eb_reg;

    bsa_word_scan #(
        .WORD_BITS (WORD_BITS)
    ) u_scan (
        .word      (rdata_reg),
        .fill_bits (wrem_reg[BIT_W-1:0]),
        .full      (wrem_full),
        .found     (scan_found),
        .onehot    (scan_onehot),
        .index     (scan_index)
    );

    // bitmap memory, one port at addr_reg
    always_comb
    begin
        mem_we    = 1'b0;
        mem_wdata = '0;
        unique case (state_reg)
            bsa_pkg::S_CLR:
            begin
                mem_we = 1'b1;
            end
            bsa_pkg::S_EVAL:
            begin
                mem_we    = scan_found;
                mem_wdata = rdata_reg | scan_onehot;
            end
            bsa_pkg::S_FCLR:
            begin
                mem_we    = 1'b1;
                mem_wdata = rdata_reg & ~(WORD_BITS'(1) << bit_reg);
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[addr_reg] <= mem_wdata;
        end
        rdata_reg <= mem[addr_reg];
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        addr_next       = addr_reg;
        cl_next         = cl_reg;
        pos_next        = pos_reg;
        wrem_next       = wrem_reg;
        cbase_next      = cbase_reg;
        cbase_addr_next = cbase_addr_reg;
        hint_next       = hint_reg;
        hint_addr_next  = hint_addr_reg;
        hint_base_next  = hint_base_reg;
        handle_next     = handle_reg;
        bit_next        = bit_reg;
        gh_next         = gh_reg;
        status_next     = status_reg;

        unique case (state_reg)
            bsa_pkg::S_CLR:
            begin
                if (addr_reg == ADDR_W'(TOTAL_WORDS - 1))
                begin
                    addr_next  = '0;
                    state_next = bsa_pkg::S_IDLE;
                end
                else
                begin
                    addr_next = addr_reg + ADDR_W'(1);
                end
            end
            bsa_pkg::S_IDLE:
            begin
                if (s_tvalid)
                begin
                    handle_next = s_tdata[bsa_pkg::HANDLE_W-1:0];
                    gh_next     = '0;
                    status_next = bsa_pkg::ST_DONE;
                    wrem_next   = REM_W'(SLOTS_PER_CLUSTER);
                    if (s_tuser[0] == bsa_pkg::OP_FREE)
                    begin
                        cl_next    = '0;
                        addr_next  = '0;
                        pos_next   = '0;
                        state_next = bsa_pkg::S_FCL;
                    end
                    else
                    begin
                        cl_next         = hint_reg;
                        addr_next       = hint_addr_reg;
                        pos_next        = hint_base_reg;
                        cbase_next      = hint_base_reg;
                        cbase_addr_next = hint_addr_reg;
                        state_next      = bsa_pkg::S_READ;
                    end
                end
            end
            bsa_pkg::S_READ:
            begin
                state_next = bsa_pkg::S_EVAL;
            end
            bsa_pkg::S_EVAL:
            begin
                if (scan_found)
                begin
                    gh_next        = bsa_pkg::HANDLE_W'(pos_ext + CMP_W'(scan_index));
                    hint_next      = cl_reg;
                    hint_addr_next = cbase_addr_reg;
                    hint_base_next = cbase_reg;
                    state_next     = bsa_pkg::S_MUL;
                end
                else if (wrem_reg > REM_W'(WORD_BITS))
                begin
                    addr_next  = addr_reg + ADDR_W'(1);
                    pos_next   = POS_W'(pos_p_wb);
                    wrem_next  = wrem_reg - REM_W'(WORD_BITS);
                    state_next = bsa_pkg::S_READ;
                end
                else if (last_cluster)
                begin
                    status_next = bsa_pkg::ST_NOSPACE;
                    state_next  = bsa_pkg::S_MUL;
                end
                else
                begin
                    cl_next         = cl_reg + CL_W'(1);
                    addr_next       = addr_reg + ADDR_W'(1);
                    pos_next        = POS_W'(pos_p_rem);
                    cbase_next      = POS_W'(pos_p_rem);
                    cbase_addr_next = addr_reg + ADDR_W'(1);
                    wrem_next       = REM_W'(SLOTS_PER_CLUSTER);
                    state_next      = bsa_pkg::S_READ;
                end
            end
            bsa_pkg::S_FCL:
            begin
                if (handle_ext >= pos_p_spc)
                begin
                    if (last_cluster)
                    begin
                        state_next = bsa_pkg::S_MUL;
                    end
                    else
                    begin
                        cl_next   = cl_reg + CL_W'(1);
                        pos_next  = POS_W'(pos_p_spc);
                        addr_next = addr_reg + ADDR_W'(WPC);
                    end
                end
                else
                begin
                    cbase_next      = pos_reg;
                    cbase_addr_next = addr_reg;
                    state_next      = bsa_pkg::S_FWD;
                end
            end
            bsa_pkg::S_FWD:
            begin
                if (handle_ext >= pos_p_wb)
                begin
                    pos_next  = POS_W'(pos_p_wb);
                    addr_next = addr_reg + ADDR_W'(1);
                end
                else
                begin
                    bit_next   = BIT_W'(handle_ext - pos_ext);
                    state_next = bsa_pkg::S_FCLR;
                end
            end
            bsa_pkg::S_FCLR:
            begin
                if (cl_reg < hint_reg)
                begin
                    hint_next      = cl_reg;
                    hint_addr_next = cbase_addr_reg;
                    hint_base_next = cbase_reg;
                end
                state_next = bsa_pkg::S_MUL;
            end
            bsa_pkg::S_MUL:
            begin
                if (out_free)
                begin
                    state_next = bsa_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = bsa_pkg::S_IDLE;
            end
        endcase
    end

    // output register and element_bytes
    always_comb
    begin
        out_handle_next = out_handle_reg;
        out_offset_next = out_offset_reg;
        out_status_next = out_status_reg;
        ovalid_next     = ovalid_reg;
        if (state_reg == bsa_pkg::S_MUL && out_free)
        begin
            out_handle_next = gh_reg;
            out_offset_next = prod[bsa_pkg::OFFSET_W-1:0];
            out_status_next = status_reg;
            ovalid_next     = 1'b1;
        end
        else if (m_tready)
        begin
            ovalid_next = 1'b0;
        end
        eb_next = cfg_we ? cfg_wdata : eb_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= bsa_pkg::S_CLR;
            addr_reg       <= '0;
            cl_reg         <= '0;
            pos_reg        <= '0;
            wrem_reg       <= '0;
            cbase_reg      <= '0;
            cbase_addr_reg <= '0;
            hint_reg       <= '0;
            hint_addr_reg  <= '0;
            hint_base_reg  <= '0;
            eb_reg         <= bsa_pkg::EBYTES_RESET;
            ovalid_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            addr_reg       <= addr_next;
            cl_reg         <= cl_next;
            pos_reg        <= pos_next;
            wrem_reg       <= wrem_next;
            cbase_reg      <= cbase_next;
            cbase_addr_reg <= cbase_addr_next;
            hint_reg       <= hint_next;
            hint_addr_reg  <= hint_addr_next;
            hint_base_reg  <= hint_base_next;
            eb_reg         <= eb_next;
            ovalid_reg     <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        handle_reg     <= handle_next;
        bit_reg        <= bit_next;
        gh_reg         <= gh_next;
        status_reg     <= status_next;
        out_handle_reg <= out_handle_next;
        out_offset_reg <= out_offset_next;
        out_status_reg <= out_status_next;
    end

    assign s_tready = (state_reg == bsa_pkg::S_IDLE);
    assign m_tvalid = ovalid_reg;
    assign m_tdata  = {{bsa_pkg::M_PAD_W{1'b0}}, out_offset_reg, out_handle_reg};
    assign m_tuser  = out_status_reg;

    `BSA_ASSERT(a_hint_range, hint_reg <= CL_W'(NUM_CLUSTERS - 1),
                "search hint out of range")
    `BSA_ASSERT(a_grant_moves_hint,
                (state_reg == bsa_pkg::S_EVAL && scan_found) |=> (hint_reg == $past(cl_reg)),
                "hint not moved to granting cluster")
    `BSA_ASSERT(a_nospace_zero,
                (m_tvalid && m_tuser[0] == bsa_pkg::ST_NOSPACE) |-> (m_tdata == '0),
                "no-space beat carries nonzero data")
    `BSA_ASSERT(a_free_in_word,
                (state_reg == bsa_pkg::S_FCLR) |-> (handle_ext >= pos_ext && handle_ext < pos_p_wb),
                "freed slot outside addressed word")

endmodule
